// File: src/qrr_pkg.sv
// Shared types and constants of the quorum register replica.
`default_nettype none

package qrr_pkg;

    // Field widths.
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned CLI_W    = 6;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned SRV_W    = 4;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned SCNT_W   = 5;
    localparam int unsigned FAIL_W   = 4;
    localparam int unsigned CCNT_W   = 7;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned CFG_D_W  = 7;

    // Client table entry: last operation number and relay count.
    localparam int unsigned ENTRY_W = WORD_W + CNT_W;

    // Read fan-out limits.
    localparam logic [SCNT_W-1:0] MAX_SERVERS = 5'd16;
    localparam logic [SRV_W-1:0]  RESULT_CAP  = 4'd15;

    // Command queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PW    = 1;
    localparam int unsigned Q_CW    = 2;

    // Highest command code that is executed.
    localparam logic [CMD_W-1:0] CMD_LAST = 3'd3;

    typedef enum logic [1:0] {
        CMD_DISCOVER = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_READ     = 2'd2,
        CMD_RELAY    = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISC_ACK  = 2'd0,
        KIND_WRITE_ACK = 2'd1,
        KIND_RELAY     = 2'd2,
        KIND_READ_ACK  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_SERVER_COUNT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_FAIL_BUDGET  = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_OWN_INDEX    = 2'd2;
    localparam logic [CFG_IX_W-1:0] CFG_CLIENT_COUNT = 2'd3;

    typedef struct packed {
        logic [SCNT_W-1:0] server_count;
        logic [FAIL_W-1:0] fail_budget;
        logic [SRV_W-1:0]  own_index;
        logic [CCNT_W-1:0] client_count;
    } t_cfg;

    typedef struct packed {
        t_cmd              cmd;
        logic [CLI_W-1:0]  cli;
        logic [WORD_W-1:0] op;
        logic [WORD_W-1:0] ts;
        logic [WORD_W-1:0] wr;
        logic [WORD_W-1:0] val;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

`default_nettype wire

// File: src/qrr_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module qrr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/qrr_front.sv
// Front end: configuration registers, command filtering and the command queue.
`default_nettype none

module qrr_front #(
    parameter int unsigned MAX_CLIENTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [qrr_pkg::CMD_W-1:0]      i_cmd,
    input  logic [qrr_pkg::CLI_W-1:0]      i_client_index,
    input  logic [qrr_pkg::WORD_W-1:0]     i_op_number,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_ts,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_writer,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qrr_pkg::CFG_IX_W-1:0]   i_cfg_index,
    input  logic [qrr_pkg::CFG_D_W-1:0]    i_cfg_data,
    input  qrr_pkg::t_back_stat            i_stat,
    output qrr_pkg::t_cfg                  o_cfg,
    output logic                           o_head_valid,
    output qrr_pkg::t_item                 o_head
);

    import qrr_pkg::*;

    localparam int unsigned CLI_LIM = (MAX_CLIENTS < 64) ? MAX_CLIENTS : 64;

    t_cfg            r_cfg;
    t_item           r_q [Q_DEPTH];
    logic [Q_PW-1:0] r_wp;
    logic [Q_PW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;

    logic  accept;
    logic  keep;
    logic  push;
    logic  cfg_we;
    t_item item;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_count <= 5'd1;
            r_cfg.fail_budget  <= '0;
            r_cfg.own_index    <= '0;
            r_cfg.client_count <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_SERVER_COUNT: r_cfg.server_count <= i_cfg_data[SCNT_W-1:0];
                CFG_FAIL_BUDGET:  r_cfg.fail_budget  <= i_cfg_data[FAIL_W-1:0];
                CFG_OWN_INDEX:    r_cfg.own_index    <= i_cfg_data[SRV_W-1:0];
                CFG_CLIENT_COUNT: r_cfg.client_count <= i_cfg_data[CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

    // Classify: unknown commands and unknown clients are dropped here.
    assign o_busy = (r_cnt == Q_CW'(Q_DEPTH)) || i_stat.clearing;
    assign accept = i_start && !o_busy;
    assign keep   = (i_cmd <= CMD_LAST)
                 && (CCNT_W'(i_client_index) < r_cfg.client_count)
                 && (CCNT_W'(i_client_index) < CCNT_W'(CLI_LIM));
    assign push   = accept && keep;

    always_comb begin
        item.cmd = t_cmd'(i_cmd[1:0]);
        item.cli = i_client_index;
        item.op  = i_op_number;
        item.ts  = i_msg_ts;
        item.wr  = i_msg_writer;
        item.val = i_msg_value;
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_stat.pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, i_stat.pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

endmodule

`default_nettype wire

// File: src/qrr_back.sv
// Back end: tag store, client table, command execution and result register.
`default_nettype none

module qrr_back #(
    parameter int unsigned MAX_CLIENTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  qrr_pkg::t_cfg                  i_cfg,
    input  logic                           i_head_valid,
    input  qrr_pkg::t_item                 i_head,
    output qrr_pkg::t_back_stat            o_stat,
    output logic                           o_res_valid,
    output logic [qrr_pkg::KIND_W-1:0]     o_kind,
    output logic [qrr_pkg::SRV_W-1:0]      o_dest_server,
    output logic [qrr_pkg::CLI_W-1:0]      o_dest_client,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_ts,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_writer,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_value,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_op,
    output logic                           o_last
);

    import qrr_pkg::*;

    localparam int unsigned AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int unsigned XW = (AW > CLI_W) ? AW : CLI_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACK,
        S_FAN,
        S_RELAY
    } t_state;

    function automatic logic [AW-1:0] to_addr(input logic [CLI_W-1:0] c);
        logic [XW-1:0] x;
        x = XW'(c);
        return x[AW-1:0];
    endfunction

    t_state              r_state, n_state;
    t_item               r_item, n_item;
    logic [AW-1:0]       r_clr, n_clr;
    logic [WORD_W-1:0]   r_tag_ts, n_tag_ts;
    logic [WORD_W-1:0]   r_tag_wr, n_tag_wr;
    logic [WORD_W-1:0]   r_val, n_val;
    logic [SCNT_W-1:0]   r_srv, n_srv;
    logic [SRV_W-1:0]    r_n, n_n;
    logic [SRV_W-1:0]    r_total, n_total;
    logic                r_res_valid, n_res_valid;
    t_kind               r_kind, n_kind;
    logic [SRV_W-1:0]    r_dsrv, n_dsrv;
    logic [CLI_W-1:0]    r_dcli, n_dcli;
    logic [WORD_W-1:0]   r_ots, n_ots;
    logic [WORD_W-1:0]   r_owr, n_owr;
    logic [WORD_W-1:0]   r_oval, n_oval;
    logic [WORD_W-1:0]   r_oop, n_oop;
    logic                r_last, n_last;

    logic                pop;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                larger;
    logic [WORD_W-1:0]   a_ts, a_wr, a_val;
    logic [SCNT_W-1:0]   limit;
    logic [SCNT_W-1:0]   total_full;
    logic [SRV_W-1:0]    total;
    logic [WORD_W-1:0]   lop_rd, lop_new;
    logic [CNT_W-1:0]    cnt_rd, cnt_a, cnt_b;
    logic [SCNT_W-1:0]   quorum;
    logic                hit;
    logic                is_last;

    // Client table: last operation number and relay count per client.
    qrr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLIENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (to_addr(i_head.cli)),
        .o_rdata (ram_rdata)
    );

    // Tag comparison, ordered by timestamp and then writer id.
    assign larger = (r_item.ts > r_tag_ts)
                 || ((r_item.ts == r_tag_ts) && (r_item.wr > r_tag_wr));
    assign a_ts   = larger ? r_item.ts  : r_tag_ts;
    assign a_wr   = larger ? r_item.wr  : r_tag_wr;
    assign a_val  = larger ? r_item.val : r_val;

    // Number of relay results for a read: all servers but this one, capped.
    assign limit      = (i_cfg.server_count < MAX_SERVERS) ? i_cfg.server_count : MAX_SERVERS;
    assign total_full = limit - SCNT_W'(SCNT_W'(i_cfg.own_index) < limit);
    assign total      = (total_full > SCNT_W'(RESULT_CAP)) ? RESULT_CAP
                                                          : total_full[SRV_W-1:0];
    assign is_last    = ((r_n + 1'b1) == r_total);

    // Relay counter update.
    assign lop_rd  = ram_rdata[ENTRY_W-1:CNT_W];
    assign cnt_rd  = ram_rdata[CNT_W-1:0];
    assign lop_new = (lop_rd < r_item.op) ? r_item.op : lop_rd;
    assign cnt_a   = (lop_rd < r_item.op) ? CNT_W'(1) : cnt_rd;
    assign cnt_b   = ((lop_new == r_item.op) && (cnt_a != '1)) ? cnt_a + 1'b1 : cnt_a;
    assign quorum  = i_cfg.server_count - SCNT_W'(i_cfg.fail_budget);
    assign hit     = (SCNT_W'(i_cfg.fail_budget) < i_cfg.server_count)
                  && (cnt_b == CNT_W'(quorum));

    // Next-state and datapath logic.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_clr       = r_clr;
        n_tag_ts    = r_tag_ts;
        n_tag_wr    = r_tag_wr;
        n_val       = r_val;
        n_srv       = r_srv;
        n_n         = r_n;
        n_total     = r_total;
        n_res_valid = 1'b0;
        n_kind      = r_kind;
        n_dsrv      = r_dsrv;
        n_dcli      = r_dcli;
        n_ots       = r_ots;
        n_owr       = r_owr;
        n_oval      = r_oval;
        n_oop       = r_oop;
        n_last      = 1'b0;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = to_addr(r_item.cli);
        ram_wdata   = {lop_new, hit ? CNT_W'(1) : cnt_b};

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == AW'(MAX_CLIENTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    pop    = 1'b1;
                    n_item = i_head;
                    case (i_head.cmd)
                        CMD_READ: begin
                            n_srv   = '0;
                            n_n     = '0;
                            n_total = total;
                            n_state = (total == '0) ? S_IDLE : S_FAN;
                        end
                        CMD_RELAY: n_state = S_RELAY;
                        default:   n_state = S_ACK;
                    endcase
                end
            end
            S_ACK: begin
                n_res_valid = 1'b1;
                n_last      = 1'b1;
                n_dsrv      = '0;
                n_dcli      = r_item.cli;
                n_oop       = r_item.op;
                if (r_item.cmd == CMD_DISCOVER) begin
                    n_kind = KIND_DISC_ACK;
                    n_ots  = r_tag_ts;
                    n_owr  = '0;
                    n_oval = '0;
                end else begin
                    n_kind   = KIND_WRITE_ACK;
                    n_tag_ts = a_ts;
                    n_tag_wr = a_wr;
                    n_val    = a_val;
                    n_ots    = a_ts;
                    n_owr    = a_wr;
                    n_oval   = a_val;
                end
                n_state = S_IDLE;
            end
            S_FAN: begin
                n_srv = r_srv + 1'b1;
                if (r_srv != SCNT_W'(i_cfg.own_index)) begin
                    n_res_valid = 1'b1;
                    n_last      = is_last;
                    n_kind      = KIND_RELAY;
                    n_dsrv      = r_srv[SRV_W-1:0];
                    n_dcli      = r_item.cli;
                    n_ots       = r_tag_ts;
                    n_owr       = r_tag_wr;
                    n_oval      = r_val;
                    n_oop       = r_item.op;
                    n_n         = r_n + 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RELAY: begin
                n_tag_ts = a_ts;
                n_tag_wr = a_wr;
                n_val    = a_val;
                ram_we   = 1'b1;
                if (hit) begin
                    n_res_valid = 1'b1;
                    n_last      = 1'b1;
                    n_kind      = KIND_READ_ACK;
                    n_dsrv      = '0;
                    n_dcli      = r_item.cli;
                    n_ots       = a_ts;
                    n_owr       = a_wr;
                    n_oval      = a_val;
                    n_oop       = r_item.op;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, tag store and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_tag_ts    <= '0;
            r_tag_wr    <= '0;
            r_val       <= '0;
            r_res_valid <= 1'b0;
            r_last      <= 1'b0;
            r_srv       <= '0;
            r_n         <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_tag_ts    <= n_tag_ts;
            r_tag_wr    <= n_tag_wr;
            r_val       <= n_val;
            r_res_valid <= n_res_valid;
            r_last      <= n_last;
            r_srv       <= n_srv;
            r_n         <= n_n;
            r_total     <= n_total;
            r_item      <= n_item;
            r_kind      <= n_kind;
            r_dsrv      <= n_dsrv;
            r_dcli      <= n_dcli;
            r_ots       <= n_ots;
            r_owr       <= n_owr;
            r_oval      <= n_oval;
            r_oop       <= n_oop;
        end
    end

    assign o_stat.pop      = pop;
    assign o_stat.clearing = (r_state == S_CLEAR);

    assign o_res_valid   = r_res_valid;
    assign o_kind        = r_kind;
    assign o_dest_server = r_dsrv;
    assign o_dest_client = r_dcli;
    assign o_out_ts      = r_ots;
    assign o_out_writer  = r_owr;
    assign o_out_value   = r_oval;
    assign o_out_op      = r_oop;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// File: src/quorum_register_replica_unit.sv
// Top level of the quorum register replica: front end, back end and checks.
`default_nettype none

// One replica of a multi-writer atomic register. A command is taken when
// i_start is high and o_busy is low; results leave one per cycle on
// o_res_valid and cannot be held off. A two-entry command queue sits
// between the front end and the back end, so o_busy rises when it is full
// or while the client table is cleared. In the back end a discover, write
// or relay is popped in one state and then executed against the tag
// registers and the registered client table read in another, and a read
// is popped and then walks the server indexes, one relay result per index
// other than this one, up to fifteen relay results; a new command is not
// popped until the last one is done. Dropped commands never enter the
// queue. After reset all MAX_CLIENTS client table entries are cleared, one
// entry a cycle, with o_busy high; configuration writes are taken throughout.
module quorum_register_replica_unit #(
    parameter int unsigned MAX_CLIENTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [qrr_pkg::CMD_W-1:0]      i_cmd,
    input  logic [qrr_pkg::CLI_W-1:0]      i_client_index,
    input  logic [qrr_pkg::WORD_W-1:0]     i_op_number,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_ts,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_writer,
    input  logic [qrr_pkg::WORD_W-1:0]     i_msg_value,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [qrr_pkg::CFG_IX_W-1:0]   i_cfg_index,
    input  logic [qrr_pkg::CFG_D_W-1:0]    i_cfg_data,
    output logic                           o_res_valid,
    output logic [qrr_pkg::KIND_W-1:0]     o_kind,
    output logic [qrr_pkg::SRV_W-1:0]      o_dest_server,
    output logic [qrr_pkg::CLI_W-1:0]      o_dest_client,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_ts,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_writer,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_value,
    output logic [qrr_pkg::WORD_W-1:0]     o_out_op,
    output logic                           o_last
);

    import qrr_pkg::*;

    t_cfg       w_cfg;
    t_back_stat w_stat;
    logic       w_head_valid;
    t_item      w_head;

    // Command intake and configuration.
    qrr_front #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_client_index (i_client_index),
        .i_op_number    (i_op_number),
        .i_msg_ts       (i_msg_ts),
        .i_msg_writer   (i_msg_writer),
        .i_msg_value    (i_msg_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_stat         (w_stat),
        .o_cfg          (w_cfg),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head)
    );

    // Command execution.
    qrr_back #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_head_valid  (w_head_valid),
        .i_head        (w_head),
        .o_stat        (w_stat),
        .o_res_valid   (o_res_valid),
        .o_kind        (o_kind),
        .o_dest_server (o_dest_server),
        .o_dest_client (o_dest_client),
        .o_out_ts      (o_out_ts),
        .o_out_writer  (o_out_writer),
        .o_out_value   (o_out_value),
        .o_out_op      (o_out_op),
        .o_last        (o_last)
    );

    // Every transaction other than a read relay is the only result of its command.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind != KIND_RELAY)) |-> o_last)
        else $error("single-result transaction without last");

    // Only read relays carry a target server.
    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind != KIND_RELAY)) |-> (o_dest_server == '0))
        else $error("target server set on a reply");

    // No result leaves and no command is popped while the client table is being cleared.
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> (!o_res_valid && !w_stat.pop))
        else $error("activity during table clear");

    // Intake is closed while the client table is being cleared.
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> o_busy)
        else $error("intake open during table clear");

endmodule

`default_nettype wire
